### design/modexp_pkg.sv
// shared constants and control types for the modular exponentiation core
`timescale 1ns / 1ps

package modexp_pkg;

    // field widths
    localparam int BASE_W  = 30;
    localparam int EXP_W   = 32;
    localparam int POWER_W = 30;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;

    // number of exponent bits scanned
    localparam int EXP_BITS = 32;
    localparam logic [EXP_W-1:0] EXP_MASK = (EXP_BITS >= EXP_W) ? {EXP_W{1'b1}} :
        EXP_W'((64'd1 << EXP_BITS) - 64'd1);

    // prime modulus and barrett reduction constants
    localparam int RED_W = 32;
    localparam logic [RED_W-1:0] PRIME_MOD = 32'd1000000007;
    localparam logic [RED_W-1:0] PRIME_MOD_X2 = 32'd2000000014;
    localparam int BARRETT_K = 30;
    localparam int MU_W = 31;
    localparam logic [MU_W-1:0] BARRETT_MU =
        MU_W'((64'd1 << (2 * BARRETT_K)) / 64'd1000000007);

    // modular multiplier pipeline depth
    localparam int MM_STAGES = 4;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic issue;
        logic update;
        logic emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic exp_zero;
        logic mm_done;
        logic out_free;
    } t_sts;

endpackage

### design/modular_exponentiation_core.sv
// top level of the modular exponentiation core
`timescale 1ns / 1ps

// Computes base^exponent mod 1000000007 by right-to-left square-and-multiply,
// one item at a time. Each exponent bit takes an issue step plus a pass through
// the 4-stage multiply-mod pipeline (product, barrett quotient, quotient times
// modulus, subtract and correct), with the square and the accumulator product
// running side by side. The scan stops at the highest set exponent bit, so the
// time from input beat to output beat grows with the bit length of the exponent.
// A base up to 2^30-1 is accepted and reduced once on entry. The result sits
// in an output register, so the next input beat is taken while it waits.

module modular_exponentiation_core
    import modexp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [29:0] base, [61:30] exponent, [63:62] zero
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [29:0] power, [31:30] zero
    output logic [M_TDATA_W-1:0]  o_m_tdata
);

    t_cmd               w_cmd;
    t_sts               w_sts;
    logic [POWER_W-1:0] w_power;

    // controller
    modexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath
    modexp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_base      (i_s_tdata[BASE_W-1:0]),
        .i_exponent  (i_s_tdata[BASE_W+EXP_W-1:BASE_W]),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_power     (w_power)
    );

    assign o_m_tdata = {{(M_TDATA_W-POWER_W){1'b0}}, w_power};

endmodule

### design/modexp_mulmod.sv
// pipelined multiply modulo the prime with barrett reduction
`timescale 1ns / 1ps

module modexp_mulmod
    import modexp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [BASE_W-1:0]  i_a,
    input  logic [BASE_W-1:0]  i_b,
    output logic               o_valid,
    output logic [BASE_W-1:0]  o_result
);

    logic [MM_STAGES-1:0]       r_valid;
    logic [2*BASE_W-1:0]        r_prod;
    logic [2*BARRETT_K+1:0]     r_q2;
    logic [RED_W-1:0]           r_x1;
    logic [RED_W-1:0]           r_x2;
    logic [RED_W-1:0]           r_q3p;
    logic [BASE_W-1:0]          r_result;

    logic [2*BASE_W-1:0]        w_prod;
    logic [2*BARRETT_K+1:0]     w_q2;
    logic [RED_W-1:0]           w_q3p;
    logic [RED_W-1:0]           w_r;
    logic [RED_W-1:0]           w_r1;
    logic [RED_W-1:0]           w_r2;
    logic [BASE_W-1:0]          n_result;

    // full product, then q1 * mu, then q3 * p (low bits only)
    assign w_prod = i_a * i_b;
    assign w_q2   = r_prod[2*BASE_W-1:BARRETT_K-1] * BARRETT_MU;
    assign w_q3p  = r_q2[2*BARRETT_K+1:BARRETT_K+1] * PRIME_MOD;

    // remainder lies below three times the modulus
    assign w_r  = r_x2 - r_q3p;
    assign w_r1 = w_r - PRIME_MOD;
    assign w_r2 = w_r - PRIME_MOD_X2;

    always_comb begin
        if (w_r >= PRIME_MOD_X2) begin
            n_result = w_r2[BASE_W-1:0];
        end else if (w_r >= PRIME_MOD) begin
            n_result = w_r1[BASE_W-1:0];
        end else begin
            n_result = w_r[BASE_W-1:0];
        end
    end

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[MM_STAGES-2:0], i_valid};
        end
    end

    // data pipe
    always_ff @(posedge i_clk) begin
        r_prod   <= w_prod;
        r_q2     <= w_q2;
        r_x1     <= r_prod[RED_W-1:0];
        r_q3p    <= w_q3p;
        r_x2     <= r_x1;
        r_result <= n_result;
    end

    assign o_valid  = r_valid[MM_STAGES-1];
    assign o_result = r_result;

endmodule

### design/modexp_datapath.sv
// exponent shifter, square and accumulator registers, output register
`timescale 1ns / 1ps

module modexp_datapath
    import modexp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [BASE_W-1:0]    i_base,
    input  logic [EXP_W-1:0]     i_exponent,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [POWER_W-1:0]   o_power
);

    logic [BASE_W-1:0]   r_sq;
    logic [BASE_W-1:0]   r_acc;
    logic [EXP_W-1:0]    r_exp;
    logic [POWER_W-1:0]  r_power;
    logic                r_out_valid;

    logic [BASE_W-1:0]   w_base_red;
    logic [RED_W-1:0]    w_base_ext;
    logic                w_sq_valid;
    logic                w_mul_valid;
    logic [BASE_W-1:0]   w_sq_res;
    logic [BASE_W-1:0]   w_mul_res;

    // base may sit up to one modulus too high
    assign w_base_ext = {{(RED_W-BASE_W){1'b0}}, i_base};
    assign w_base_red = (w_base_ext >= PRIME_MOD) ?
        BASE_W'(w_base_ext - PRIME_MOD) : i_base;

    // squaring unit
    modexp_mulmod u_square (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_cmd.issue),
        .i_a      (r_sq),
        .i_b      (r_sq),
        .o_valid  (w_sq_valid),
        .o_result (w_sq_res)
    );

    // accumulator multiply unit
    modexp_mulmod u_multiply (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_cmd.issue),
        .i_a      (r_acc),
        .i_b      (r_sq),
        .o_valid  (w_mul_valid),
        .o_result (w_mul_res)
    );

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sq  <= w_base_red;
            r_acc <= BASE_W'(1);
            r_exp <= i_exponent & EXP_MASK;
        end else if (i_cmd.update) begin
            r_sq  <= w_sq_res;
            if (r_exp[0]) begin
                r_acc <= w_mul_res;
            end
            r_exp <= {1'b0, r_exp[EXP_W-1:1]};
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_power <= r_acc;
        end
    end

    assign o_sts.exp_zero = (r_exp == '0);
    assign o_sts.mm_done  = w_sq_valid & w_mul_valid;
    assign o_sts.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_power        = r_power;

endmodule

### design/modexp_ctrl.sv
// controller state machine sequencing one exponentiation at a time
`timescale 1ns / 1ps

module modexp_ctrl
    import modexp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_WAIT   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                // no input beat is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.exp_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.issue = 1'b1;
                    n_state     = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_sts.mm_done) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
